/* src/stok_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stok_pkg: shared types and constants of the source tokenizer
// Beat formats, token type codes, held-delimiter codes and the small
// character classification functions.
// ----------------------------------------------------------------------------
package stok_pkg;

  typedef struct packed {
    logic       has_char;
    logic [7:0] ch;
    logic       line_end;
  } stok_in_t;

  typedef struct packed {
    logic [4:0]  token_type;
    logic [15:0] line_number;
    logic [9:0]  start_col;
    logic [10:0] token_len;
    logic        last;
  } stok_out_t;

  // token types
  localparam logic [4:0] TT_LPAREN   = 5'd0;
  localparam logic [4:0] TT_RPAREN   = 5'd1;
  localparam logic [4:0] TT_LBRACE   = 5'd2;
  localparam logic [4:0] TT_RBRACE   = 5'd3;
  localparam logic [4:0] TT_COMMA    = 5'd4;
  localparam logic [4:0] TT_DOT      = 5'd5;
  localparam logic [4:0] TT_MINUS    = 5'd6;
  localparam logic [4:0] TT_PLUS     = 5'd7;
  localparam logic [4:0] TT_SEMI     = 5'd8;
  localparam logic [4:0] TT_SLASH    = 5'd9;
  localparam logic [4:0] TT_STAR     = 5'd10;
  localparam logic [4:0] TT_NOT      = 5'd11;
  localparam logic [4:0] TT_NE       = 5'd12;
  localparam logic [4:0] TT_ASSIGN   = 5'd13;
  localparam logic [4:0] TT_EQ       = 5'd14;
  localparam logic [4:0] TT_GT       = 5'd15;
  localparam logic [4:0] TT_GE       = 5'd16;
  localparam logic [4:0] TT_LT       = 5'd17;
  localparam logic [4:0] TT_LE       = 5'd18;
  localparam logic [4:0] TT_AND      = 5'd19;
  localparam logic [4:0] TT_OR       = 5'd20;
  localparam logic [4:0] TT_IDENT    = 5'd21;
  localparam logic [4:0] TT_KW_ELSE  = 5'd22;
  localparam logic [4:0] TT_KW_FALSE = 5'd23;
  localparam logic [4:0] TT_KW_FOR   = 5'd24;
  localparam logic [4:0] TT_KW_IF    = 5'd25;
  localparam logic [4:0] TT_KW_RET   = 5'd26;
  localparam logic [4:0] TT_KW_TRUE  = 5'd27;
  localparam logic [4:0] TT_KW_WHILE = 5'd28;
  localparam logic [4:0] TT_KW_INT   = 5'd29;
  localparam logic [4:0] TT_KW_CHAR  = 5'd30;

  // held delimiter codes
  localparam logic [2:0] PD_NONE   = 3'd0;
  localparam logic [2:0] PD_BANG   = 3'd1;
  localparam logic [2:0] PD_EQUALS = 3'd2;
  localparam logic [2:0] PD_GT     = 3'd3;
  localparam logic [2:0] PD_LT     = 3'd4;
  localparam logic [2:0] PD_AMP    = 3'd5;
  localparam logic [2:0] PD_BAR    = 3'd6;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  // keyword spellings, first character in the high byte
  localparam logic [31:0] KW_ELSE  = "else";
  localparam logic [39:0] KW_FALSE = "false";
  localparam logic [23:0] KW_FOR   = "for";
  localparam logic [15:0] KW_IF    = "if";
  localparam logic [47:0] KW_RET   = "return";
  localparam logic [31:0] KW_TRUE  = "true";
  localparam logic [39:0] KW_WHILE = "while";
  localparam logic [23:0] KW_INT   = "int";
  localparam logic [31:0] KW_CHAR  = "char";

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
  endfunction

  function automatic logic [2:0] starter_code(input logic [7:0] c);
    logic [2:0] code;
    unique case (c)
      "!":     code = PD_BANG;
      "=":     code = PD_EQUALS;
      ">":     code = PD_GT;
      "<":     code = PD_LT;
      "&":     code = PD_AMP;
      "|":     code = PD_BAR;
      default: code = PD_NONE;
    endcase
    return code;
  endfunction

  // {hit, type} for one-character delimiters that are never held
  function automatic logic [5:0] single_type(input logic [7:0] c);
    logic [5:0] r;
    unique case (c)
      "(":     r = {1'b1, TT_LPAREN};
      ")":     r = {1'b1, TT_RPAREN};
      "{":     r = {1'b1, TT_LBRACE};
      "}":     r = {1'b1, TT_RBRACE};
      ",":     r = {1'b1, TT_COMMA};
      ".":     r = {1'b1, TT_DOT};
      "-":     r = {1'b1, TT_MINUS};
      "+":     r = {1'b1, TT_PLUS};
      ";":     r = {1'b1, TT_SEMI};
      "/":     r = {1'b1, TT_SLASH};
      "*":     r = {1'b1, TT_STAR};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] held_char(input logic [2:0] p);
    logic [7:0] r;
    unique case (p)
      PD_BANG:   r = "!";
      PD_EQUALS: r = "=";
      PD_GT:     r = ">";
      PD_LT:     r = "<";
      PD_AMP:    r = "&";
      PD_BAR:    r = "|";
      default:   r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] held_second(input logic [2:0] p);
    logic [7:0] r;
    unique case (p)
      PD_BANG, PD_EQUALS, PD_GT, PD_LT: r = "=";
      PD_AMP:  r = "&";
      PD_BAR:  r = "|";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] held_single(input logic [2:0] p);
    logic [4:0] r;
    unique case (p)
      PD_BANG:   r = TT_NOT;
      PD_EQUALS: r = TT_ASSIGN;
      PD_GT:     r = TT_GT;
      PD_LT:     r = TT_LT;
      default:   r = TT_IDENT;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] held_pair(input logic [2:0] p);
    logic [4:0] r;
    unique case (p)
      PD_BANG:   r = TT_NE;
      PD_EQUALS: r = TT_EQ;
      PD_GT:     r = TT_GE;
      PD_LT:     r = TT_LE;
      PD_AMP:    r = TT_AND;
      PD_BAR:    r = TT_OR;
      default:   r = TT_IDENT;
    endcase
    return r;
  endfunction

  // w: newest characters, newest in the low byte; n: run length, 7 when longer
  function automatic logic [4:0] kw_match(input logic [47:0] w, input logic [2:0] n);
    logic [4:0] r;
    r = TT_IDENT;
    if      (n == 3'd4 && w[31:0] == KW_ELSE)  r = TT_KW_ELSE;
    else if (n == 3'd5 && w[39:0] == KW_FALSE) r = TT_KW_FALSE;
    else if (n == 3'd3 && w[23:0] == KW_FOR)   r = TT_KW_FOR;
    else if (n == 3'd2 && w[15:0] == KW_IF)    r = TT_KW_IF;
    else if (n == 3'd6 && w[47:0] == KW_RET)   r = TT_KW_RET;
    else if (n == 3'd4 && w[31:0] == KW_TRUE)  r = TT_KW_TRUE;
    else if (n == 3'd5 && w[39:0] == KW_WHILE) r = TT_KW_WHILE;
    else if (n == 3'd3 && w[23:0] == KW_INT)   r = TT_KW_INT;
    else if (n == 3'd4 && w[31:0] == KW_CHAR)  r = TT_KW_CHAR;
    return r;
  endfunction

endpackage

/* src/source_tokenizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_core: streaming lexical analyser
// Turns a character stream with line-end marks into typed tokens carrying
// line, start column and length.
// ----------------------------------------------------------------------------
// Path: a beat's tokens pass the input stage register, then the token queue.
// Throughput: one input beat per cycle while beats give at most one token
// each and the receiver keeps up; input stalls while the 4-entry token
// queue holds more than one token.
// Reset: synchronous, active low; empties stage and queue, line counter to 1,
// column, run and held delimiter to zero.
module source_tokenizer_core
  import stok_pkg::*;
#(
  parameter int MAX_LINE_LEN = 1024,
  parameter int KEYWORD_MAX  = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  stok_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output stok_out_t out_data
);

  localparam int COL_W = $clog2(MAX_LINE_LEN);
  localparam int LEN_W = $clog2(MAX_LINE_LEN + 1);
  localparam int WIN_W = 8 * KEYWORD_MAX;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_LINE_LEN - 1);
  localparam logic [LEN_W-1:0] LEN_SAT  = LEN_W'(MAX_LINE_LEN);

  // current identifier/keyword run
  typedef struct packed {
    logic [COL_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [WIN_W-1:0] win;
  } run_t;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [9:0] col_field(input logic [COL_W-1:0] c);
    logic [COL_W+9:0] x;
    x = {10'd0, c};
    return x[9:0];
  endfunction

  function automatic logic [10:0] len_field(input logic [LEN_W-1:0] l);
    logic [LEN_W+10:0] x;
    x = {11'd0, l};
    return x[10:0];
  endfunction

  function automatic logic [COL_W-1:0] col_inc(input logic [COL_W-1:0] c);
    return (c == COL_LAST) ? '0 : c + COL_W'(1);
  endfunction

  function automatic logic [COL_W-1:0] col_prev(input logic [COL_W-1:0] c);
    return (c == '0) ? COL_LAST : c - COL_W'(1);
  endfunction

  function automatic run_t run_append(input run_t r, input logic [7:0] c,
                                      input logic [COL_W-1:0] col);
    run_t o;
    o = r;
    if (r.len == '0) o.start = col;
    if (r.len < LEN_SAT) o.len = r.len + LEN_W'(1);
    o.win = {r.win[WIN_W-9:0], c};
    return o;
  endfunction

  function automatic stok_out_t run_tok(input run_t r, input logic [15:0] ln);
    stok_out_t t;
    logic [2:0] n;
    n = (r.len < LEN_W'(7)) ? r.len[2:0] : 3'd7;
    t.token_type  = kw_match(r.win[47:0], n);
    t.line_number = ln;
    t.start_col   = col_field(r.start);
    t.token_len   = len_field(r.len);
    t.last        = 1'b0;
    return t;
  endfunction

  function automatic stok_out_t delim_tok(input logic [4:0] ty, input logic [15:0] ln,
                                          input logic [COL_W-1:0] col,
                                          input logic [1:0] l);
    stok_out_t t;
    t.token_type  = ty;
    t.line_number = ln;
    t.start_col   = col_field(col);
    t.token_len   = {9'd0, l};
    t.last        = 1'b0;
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Input stage: hold one beat until the queue has room for its tokens
  // --------------------------------------------------------------------------
  logic       stg_valid_r;
  stok_in_t   stg_data_r;
  logic       go;
  logic [2:0] cnt_r;

  // three free entries are needed before a beat may advance
  assign go       = stg_valid_r && (cnt_r <= 3'd1);
  assign in_ready = !stg_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_data_r <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // Lexer state
  // --------------------------------------------------------------------------
  logic [15:0]      line_r, line_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  run_t             run_r, run_nxt;
  logic [2:0]       pend_r, pend_nxt;

  stok_out_t        slot [3];
  logic [1:0]       n_tok;

  // One pass over the staged beat, in the order the tokens leave:
  // resolve the held character, classify the new one, then flush at line end.
  always_comb begin
    logic [7:0] c;
    logic [5:0] st;
    logic [2:0] code;
    run_t       run;
    logic [COL_W-1:0] col;
    logic [2:0] pend;
    logic [15:0] line;
    logic [1:0] n;

    c    = stg_data_r.ch;
    st   = single_type(c);
    code = starter_code(c);
    run  = run_r;
    col  = col_r;
    line = line_r;
    // the spare code means nothing is held
    pend = (pend_r > PD_BAR) ? PD_NONE : pend_r;
    n    = 2'd0;
    for (int i = 0; i < 3; i++) slot[i] = '0;

    if (stg_data_r.has_char) begin
      if (pend != PD_NONE && c == held_second(pend)) begin
        // two-character delimiter completes
        if (run.len != '0) begin
          slot[n] = run_tok(run, line);
          n       = n + 2'd1;
          run     = '0;
        end
        slot[n] = delim_tok(held_pair(pend), line, col_prev(col), 2'd2);
        n       = n + 2'd1;
        pend    = PD_NONE;
      end else begin
        if (pend >= PD_BANG && pend <= PD_LT) begin
          if (run.len != '0) begin
            slot[n] = run_tok(run, line);
            n       = n + 2'd1;
            run     = '0;
          end
          slot[n] = delim_tok(held_single(pend), line, col_prev(col), 2'd1);
          n       = n + 2'd1;
        end else if (pend == PD_AMP || pend == PD_BAR) begin
          // lone & or | is an ordinary run character
          run = run_append(run, held_char(pend), col_prev(col));
        end
        pend = PD_NONE;

        if (is_space(c)) begin
          if (run.len != '0) begin
            slot[n] = run_tok(run, line);
            n       = n + 2'd1;
            run     = '0;
          end
        end else if (code != PD_NONE) begin
          pend = code;
        end else if (st[5]) begin
          if (run.len != '0) begin
            slot[n] = run_tok(run, line);
            n       = n + 2'd1;
            run     = '0;
          end
          slot[n] = delim_tok(st[4:0], line, col, 2'd1);
          n       = n + 2'd1;
        end else begin
          run = run_append(run, c, col);
        end
      end
      col = col_inc(col);
    end

    if (stg_data_r.line_end) begin
      if (pend >= PD_BANG && pend <= PD_LT) begin
        if (run.len != '0) begin
          slot[n] = run_tok(run, line);
          n       = n + 2'd1;
          run     = '0;
        end
        slot[n] = delim_tok(held_single(pend), line, col_prev(col), 2'd1);
        n       = n + 2'd1;
      end else if (pend == PD_AMP || pend == PD_BAR) begin
        run = run_append(run, held_char(pend), col_prev(col));
      end
      pend = PD_NONE;
      if (run.len != '0) begin
        slot[n] = run_tok(run, line);
        n       = n + 2'd1;
        run     = '0;
      end
      if (line != LINE_MAX) line = line + 16'd1;
      col = '0;
    end

    // mark the final token of the beat
    if (n != 2'd0) slot[n - 2'd1].last = 1'b1;

    n_tok    = n;
    run_nxt  = run;
    col_nxt  = col;
    line_nxt = line;
    pend_nxt = pend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= 16'd1;
      col_r  <= '0;
      run_r  <= '0;
      pend_r <= PD_NONE;
    end else if (go) begin
      line_r <= line_nxt;
      col_r  <= col_nxt;
      run_r  <= run_nxt;
      pend_r <= pend_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Token queue: up to three pushes per cycle, one pop
  // --------------------------------------------------------------------------
  stok_out_t  q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] push_n;
  logic       pop;

  assign push_n    = go ? {1'b0, n_tok} : 3'd0;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (push_n > 3'(i)) begin
        q_r[wr_ptr_r + 2'(i)] <= slot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[1:0];
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_r + push_n - {2'b00, pop};
    end
  end

endmodule

/* src/stok_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stok_checker: port-level checks of the source tokenizer
// Watches the token channel for reset, handshake and token shape rules.
// ----------------------------------------------------------------------------
module stok_checker
  import stok_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input stok_out_t out_data
);

  // nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("token offered after reset");

  // a stalled token beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("token beat changed while stalled");

  // tokens have a real line, a length and a defined type
  a_token_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.line_number != 16'd0 && out_data.token_len != 11'd0
                  && out_data.token_type <= TT_KW_CHAR)
    else $error("malformed token");

  // two-character delimiters are two long
  a_pair_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_type == TT_NE || out_data.token_type == TT_EQ ||
                  out_data.token_type == TT_GE || out_data.token_type == TT_LE ||
                  out_data.token_type == TT_AND || out_data.token_type == TT_OR)
    |-> out_data.token_len == 11'd2)
    else $error("pair delimiter with wrong length");

  // single delimiters are one long
  a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_type <= TT_STAR |-> out_data.token_len == 11'd1)
    else $error("single delimiter with wrong length");

endmodule

bind source_tokenizer_core stok_checker u_stok_checker (.*);

/* tb/source_tokenizer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_core_tb: self-checking bench for the streaming tokenizer
// Feeds character beats with line-end marks: a short directed set of corner
// cases, then random source-like lines mixed with byte noise. A scoreboard
// predicts each token from its own lexer state and checks every token the
// block gives, in order, under random stalls on both channels.
// ----------------------------------------------------------------------------
module source_tokenizer_core_tb;
  import stok_pkg::*;

  localparam int RANDOM_BEATS = 250;
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int STALL_LIMIT  = 1000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 38;

  // how a line of text is closed
  localparam int END_NONE    = 0;
  localparam int END_ON_CHAR = 1;
  localparam int END_BARE    = 2;

  // --------------------------------------------------------------------------
  // Token predictor and checker
  // --------------------------------------------------------------------------
  class token_scoreboard;
    stok_out_t   expected_q[$];
    stok_out_t   beat_toks[$];
    logic [15:0] line_no;
    logic [9:0]  col;
    logic [9:0]  run_col;
    logic [10:0] run_len;
    logic [47:0] window;
    logic [2:0]  held;
    int          beats;
    int          tokens;
    int          errors;

    function new();
      line_no = 16'd1;
      col     = '0;
      run_col = '0;
      run_len = '0;
      window  = '0;
      held    = PD_NONE;
      beats   = 0;
      tokens  = 0;
      errors  = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%t  %s", $realtime, msg);
    endfunction

    function void add_token(logic [4:0] kind, logic [9:0] at, logic [10:0] len);
      stok_out_t t;
      // a beat gives three tokens at most; any further one is dropped
      if (beat_toks.size() < 3) begin
        t.token_type  = kind;
        t.line_number = line_no;
        t.start_col   = at;
        t.token_len   = len;
        t.last        = 1'b0;
        beat_toks.push_back(t);
      end
    endfunction

    function logic [4:0] run_kind();
      logic [4:0] r;
      r = TT_IDENT;
      case (run_len)
        11'd2: if (window[15:0] == "if") r = TT_KW_IF;
        11'd3: begin
          if (window[23:0] == "for") r = TT_KW_FOR;
          else if (window[23:0] == "int") r = TT_KW_INT;
        end
        11'd4: begin
          if (window[31:0] == "else") r = TT_KW_ELSE;
          else if (window[31:0] == "true") r = TT_KW_TRUE;
          else if (window[31:0] == "char") r = TT_KW_CHAR;
        end
        11'd5: begin
          if (window[39:0] == "false") r = TT_KW_FALSE;
          else if (window[39:0] == "while") r = TT_KW_WHILE;
        end
        11'd6: if (window[47:0] == "return") r = TT_KW_RET;
        default: ;
      endcase
      return r;
    endfunction

    function void flush_run();
      if (run_len != 0) begin
        add_token(run_kind(), run_col, run_len);
        run_len = '0;
        window  = '0;
      end
    endfunction

    function void extend_run(logic [7:0] c, logic [9:0] at);
      if (run_len == 0) run_col = at;
      if (run_len < 11'd1024) run_len = run_len + 11'd1;
      window = {window[39:0], c};
    endfunction

    // held character not completed to a pair: lone delimiter, or & and |
    // fall back to ordinary run characters
    function void drop_held();
      logic [2:0] p;
      p    = held;
      held = PD_NONE;
      case (p)
        PD_BANG:   begin flush_run(); add_token(TT_NOT, col - 10'd1, 11'd1); end
        PD_EQUALS: begin flush_run(); add_token(TT_ASSIGN, col - 10'd1, 11'd1); end
        PD_GT:     begin flush_run(); add_token(TT_GT, col - 10'd1, 11'd1); end
        PD_LT:     begin flush_run(); add_token(TT_LT, col - 10'd1, 11'd1); end
        PD_AMP:    extend_run("&", col - 10'd1);
        PD_BAR:    extend_run("|", col - 10'd1);
        default:   ;
      endcase
    endfunction

    function void take_char(logic [7:0] c);
      logic [7:0] partner;
      logic [4:0] pair_kind;
      logic [4:0] delim_kind;
      logic       is_delim;
      logic [2:0] code;
      if (held >= PD_BANG && held <= PD_BAR) begin
        case (held)
          PD_AMP:  begin partner = "&"; pair_kind = TT_AND; end
          PD_BAR:  begin partner = "|"; pair_kind = TT_OR; end
          PD_BANG: begin partner = "="; pair_kind = TT_NE; end
          PD_GT:   begin partner = "="; pair_kind = TT_GE; end
          PD_LT:   begin partner = "="; pair_kind = TT_LE; end
          default: begin partner = "="; pair_kind = TT_EQ; end
        endcase
        if (c == partner) begin
          held = PD_NONE;
          flush_run();
          add_token(pair_kind, col - 10'd1, 11'd2);
          col = col + 10'd1;
          return;
        end
        drop_held();
      end
      held = PD_NONE;
      case (c)
        "!":     code = PD_BANG;
        "=":     code = PD_EQUALS;
        ">":     code = PD_GT;
        "<":     code = PD_LT;
        "&":     code = PD_AMP;
        "|":     code = PD_BAR;
        default: code = PD_NONE;
      endcase
      is_delim = 1'b1;
      case (c)
        "(":     delim_kind = TT_LPAREN;
        ")":     delim_kind = TT_RPAREN;
        "{":     delim_kind = TT_LBRACE;
        "}":     delim_kind = TT_RBRACE;
        ",":     delim_kind = TT_COMMA;
        ".":     delim_kind = TT_DOT;
        "-":     delim_kind = TT_MINUS;
        "+":     delim_kind = TT_PLUS;
        ";":     delim_kind = TT_SEMI;
        "/":     delim_kind = TT_SLASH;
        "*":     delim_kind = TT_STAR;
        default: begin delim_kind = TT_IDENT; is_delim = 1'b0; end
      endcase
      if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE) flush_run();
      else if (code != PD_NONE) held = code;
      else if (is_delim) begin
        flush_run();
        add_token(delim_kind, col, 11'd1);
      end else extend_run(c, col);
      col = col + 10'd1;
    endfunction

    // predict the tokens of one accepted input beat
    function void note_beat(stok_in_t b);
      beat_toks.delete();
      beats++;
      if (b.has_char) take_char(b.ch);
      if (b.line_end) begin
        drop_held();
        flush_run();
        if (line_no != LINE_MAX) line_no = line_no + 16'd1;
        col = '0;
      end
      if (beat_toks.size() > 0) beat_toks[beat_toks.size() - 1].last = 1'b1;
      foreach (beat_toks[i]) expected_q.push_back(beat_toks[i]);
    endfunction

    function void check_token(stok_out_t got);
      stok_out_t want;
      tokens++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected token: type %0d line %0d col %0d len %0d last %0b",
                         got.token_type, got.line_number, got.start_col, got.token_len,
                         got.last));
        return;
      end
      want = expected_q.pop_front();
      if (got.token_type !== want.token_type || got.line_number !== want.line_number ||
          got.start_col !== want.start_col || got.token_len !== want.token_len ||
          got.last !== want.last)
        report({$sformatf("token mismatch: expected type %0d line %0d col %0d len %0d last %0b",
                          want.token_type, want.line_number, want.start_col,
                          want.token_len, want.last),
                $sformatf(", got type %0d line %0d col %0d len %0d last %0b",
                          got.token_type, got.line_number, got.start_col,
                          got.token_len, got.last)});
    endfunction

    function void check_drained();
      if (expected_q.size() != 0)
        report($sformatf("%0d expected tokens never arrived", expected_q.size()));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  stok_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  stok_out_t out_data;

  always #2 clk = ~clk;

  source_tokenizer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  token_scoreboard sb = new();

  bit         steady = 1'b0;   // no idling on either side while set
  bit         hold_req = 1'b0; // ask the receiver for one long hold-off
  int         hold_left = 0;
  int         stall_count = 0;
  int         sent_beats = 0;
  logic [7:0] text_q[$];
  string      kw_words[9] = '{"else", "false", "for", "if", "return", "true", "while",
                              "int", "char"};
  string      pair_words[6] = '{"!=", "==", ">=", "<=", "&&", "||"};
  string      lone_chars = "(){},.-+;/*!=><&|";

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge. A token leaves only
  // after the input stage and token queue, so noting the beat first is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_beat(in_data);
      if (out_valid && out_ready) sb.check_token(out_data);
    end
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("** source_tokenizer_core: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // token queue fills and the block stalls its input.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  function automatic stok_in_t beat_of(bit has, logic [7:0] c, bit le);
    stok_in_t b;
    b.has_char = has;
    b.ch       = c;
    b.line_end = le;
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Valid stays high into the next call unless that call idles first.
  task automatic send_beat(input stok_in_t b);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b.has_char || b.line_end) sent_beats++;
    @(negedge clk);
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // send the queued text, closing the line as asked
  task automatic send_line(input int end_mode);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++)
      send_beat(beat_of(1'b1, text_q[i], end_mode == END_ON_CHAR && i == n - 1));
    if (end_mode == END_BARE || (end_mode == END_ON_CHAR && n == 0))
      send_beat(beat_of(1'b0, 8'($urandom_range(0, 255)), 1'b1));
    text_q.delete();
  endtask

  // one random source-like line: keywords, near-keywords, identifiers,
  // delimiters, pairs and lone starters, with or without separators
  function automatic void compose_line();
    int    n;
    string w;
    n = $urandom_range(0, 8);
    repeat (n) begin
      case ($urandom_range(0, 8))
        0, 1: put_text(kw_words[$urandom_range(0, 8)]);
        2: begin
          w = kw_words[$urandom_range(0, 8)];
          case ($urandom_range(0, 2))
            0:       put_text(w.substr(0, w.len() - 2));
            1:       put_text({w, "x"});
            default: put_text({"_", w});
          endcase
        end
        3, 4: begin
          repeat ($urandom_range(1, 7)) begin
            case ($urandom_range(0, 3))
              0:       text_q.push_back(8'($urandom_range(48, 57)));
              1:       text_q.push_back("_");
              default: text_q.push_back(8'($urandom_range(97, 122)));
            endcase
          end
        end
        5, 6: text_q.push_back(lone_chars[$urandom_range(0, 10)]);
        7:    put_text(pair_words[$urandom_range(0, 5)]);
        default: text_q.push_back(lone_chars[$urandom_range(11, 16)]);
      endcase
      case ($urandom_range(0, 5))
        0, 1:    ;
        2:       text_q.push_back(CH_TAB);
        default: text_q.push_back(CH_SPACE);
      endcase
    end
  endfunction

  task automatic send_random_line();
    compose_line();
    case ($urandom_range(0, 9))
      0:       send_line(END_NONE);
      1, 2, 3: send_line(END_BARE);
      default: send_line(END_ON_CHAR);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int  base;
    int  done;
    bit  held_off;
    held_off = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // lone & and | become part of the run
    put_text("a&b|c");
    send_line(END_ON_CHAR);
    // held ! at line end gives a single delimiter; held & joins the run
    put_text("x!");
    send_line(END_ON_CHAR);
    put_text("y&");
    send_line(END_ON_CHAR);
    // empty beat: must give nothing
    send_beat(beat_of(1'b0, 8'hFF, 1'b0));
    // extreme bytes form a run; tab and newline byte only separate
    send_beat(beat_of(1'b1, 8'hFF, 1'b0));
    send_beat(beat_of(1'b1, 8'h00, 1'b0));
    send_beat(beat_of(1'b1, CH_TAB, 1'b0));
    send_beat(beat_of(1'b1, CH_NEWLINE, 1'b0));
    send_beat(beat_of(1'b1, "=", 1'b1));
    // back-to-back pairs, then an empty line
    put_text("&&||<=");
    send_line(END_ON_CHAR);
    send_line(END_BARE);

    // random part; hold a stretch with no idling, then one long hold-off
    base = sent_beats;
    while (sent_beats - base < RANDOM_BEATS) begin
      done   = sent_beats - base;
      steady = (done >= 100 && done < 170);
      if (!held_off && done >= 200) begin
        hold_req = 1'b1;
        held_off = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 6))
          send_beat(beat_of(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            $urandom_range(0, 3) == 0));
      end else begin
        send_random_line();
      end
    end
    steady = 1'b0;

    // close whatever line is still open
    send_line(END_BARE);

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();

    $display("run covered %0d input beats and %0d tokens: directed corner cases, random",
             sb.beats, sb.tokens);
    $display("source lines with byte noise, a stretch without idling and a long hold-off");
    if (sb.errors == 0) begin
      $display("** source_tokenizer_core: PASSED **");
    end else begin
      $display("%0d failures", sb.errors);
      $display("** source_tokenizer_core: FAILED **");
    end
    $finish;
  end

endmodule
